### rtl/core/stq_pkg.sv
// shared constants, codes and control types for the sorted timer queue
package stq_pkg;

  localparam int NUM_ENTRIES = 16;
  localparam int TIME_W      = 32;
  localparam int ID_W        = 4;
  localparam int DELAY_W     = 32;
  localparam int IDX_W       = $clog2(NUM_ENTRIES);
  localparam int CNT_W       = $clog2(NUM_ENTRIES + 1);
  localparam int IN_DATA_W   = ((ID_W + DELAY_W + 7) / 8) * 8;
  localparam int OUT_DATA_W  = ((1 + ID_W + 7) / 8) * 8;

  localparam logic CMD_TICK     = 1'b0;
  localparam logic CMD_ADD      = 1'b1;
  localparam logic KIND_STATUS  = 1'b0;
  localparam logic KIND_EXPIRED = 1'b1;
  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_BUSY  = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ADD_SCAN,
    ST_ADD_PUT,
    ST_TICK
  } stq_state_t;

  typedef struct packed {
    logic accept;
    logic scan_step;
    logic insert;
    logic pop;
  } stq_cmd_t;

  typedef struct packed {
    logic reject;
    logic scan_hit;
    logic head_expired;
    logic out_free;
  } stq_stat_t;

endpackage

### rtl/core/stq_ctrl.sv
// controller state machine: sequences add scans, inserts and tick pops
module stq_ctrl import stq_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  input  logic      in_is_add,
  output logic      in_tready,
  input  stq_stat_t stat,
  output stq_cmd_t  cmd
);

  stq_state_t state_r;
  stq_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.accept = 1'b1;
          state_nxt  = in_is_add ? ST_ADD_SCAN : ST_TICK;
        end
      end
      ST_ADD_SCAN: begin
        if (stat.reject || stat.scan_hit) begin
          state_nxt = ST_ADD_PUT;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      ST_ADD_PUT: begin
        if (stat.out_free) begin
          cmd.insert = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      ST_TICK: begin
        // expired entries always form a prefix of the sorted queue
        if (!stat.head_expired) begin
          state_nxt = ST_IDLE;
        end else if (stat.out_free) begin
          cmd.pop = 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

### rtl/core/stq_dp.sv
// datapath: tick counter, sorted slot array, pending flags and result register
module stq_dp import stq_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  stq_cmd_t           cmd,
  output stq_stat_t          stat,
  input  logic               in_is_add,
  input  logic [ID_W-1:0]    in_entry_id,
  input  logic [DELAY_W-1:0] in_delay_ticks,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_kind,
  output logic               out_status,
  output logic [ID_W-1:0]    out_expired_id,
  output logic               out_last
);

  logic [TIME_W-1:0]      uptime_r;
  logic [TIME_W-1:0]      when_r;
  logic [ID_W-1:0]        id_r;
  logic                   reject_r;
  logic [CNT_W-1:0]       idx_r;
  logic [CNT_W-1:0]       count_r;
  logic [NUM_ENTRIES-1:0] pending_r;
  logic [ID_W-1:0]        slot_id_r  [NUM_ENTRIES];
  logic [TIME_W-1:0]      slot_exp_r [NUM_ENTRIES];
  logic                   out_valid_r;
  logic                   out_kind_r;
  logic                   out_status_r;
  logic [ID_W-1:0]        out_id_r;
  logic                   out_last_r;

  logic             id_bad;
  logic             out_free;
  logic             second_expired;
  logic [IDX_W-1:0] pos;

  assign pos      = idx_r[IDX_W-1:0];
  assign out_free = !out_valid_r || out_ready;
  assign id_bad   = (int'(in_entry_id) >= NUM_ENTRIES)
                    || pending_r[in_entry_id[IDX_W-1:0]]
                    || (count_r == CNT_W'(NUM_ENTRIES));

  assign second_expired = (count_r > CNT_W'(1)) && (slot_exp_r[1] <= uptime_r);

  assign stat.reject       = reject_r;
  assign stat.scan_hit     = (idx_r == count_r) || (slot_exp_r[pos] >= when_r);
  assign stat.head_expired = (count_r != '0) && (slot_exp_r[0] <= uptime_r);
  assign stat.out_free     = out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      uptime_r    <= '0;
      count_r     <= '0;
      pending_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.accept && !in_is_add) begin
        uptime_r <= uptime_r + TIME_W'(1);
      end
      if (cmd.insert && !reject_r) begin
        pending_r[id_r[IDX_W-1:0]] <= 1'b1;
        count_r <= count_r + CNT_W'(1);
      end
      if (cmd.pop) begin
        pending_r[slot_id_r[0][IDX_W-1:0]] <= 1'b0;
        count_r <= count_r - CNT_W'(1);
      end
      if (cmd.insert || cmd.pop) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      when_r   <= uptime_r + in_delay_ticks[TIME_W-1:0];
      id_r     <= in_entry_id;
      reject_r <= id_bad;
      idx_r    <= '0;
    end else if (cmd.scan_step) begin
      idx_r <= idx_r + CNT_W'(1);
    end
    if (cmd.insert && !reject_r) begin
      for (int j = 0; j < NUM_ENTRIES; j++) begin
        if (IDX_W'(j) == pos) begin
          slot_id_r[j]  <= id_r;
          slot_exp_r[j] <= when_r;
        end else if (j > 0 && IDX_W'(j) > pos) begin
          slot_id_r[j]  <= slot_id_r[j-1];
          slot_exp_r[j] <= slot_exp_r[j-1];
        end
      end
    end
    if (cmd.pop) begin
      for (int j = 0; j < NUM_ENTRIES - 1; j++) begin
        slot_id_r[j]  <= slot_id_r[j+1];
        slot_exp_r[j] <= slot_exp_r[j+1];
      end
    end
    if (cmd.insert) begin
      out_kind_r   <= KIND_STATUS;
      out_status_r <= reject_r ? STATUS_BUSY : STATUS_OK;
      out_id_r     <= '0;
      out_last_r   <= 1'b1;
    end else if (cmd.pop) begin
      out_kind_r   <= KIND_EXPIRED;
      out_status_r <= STATUS_OK;
      out_id_r     <= slot_id_r[0];
      out_last_r   <= !second_expired;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_kind       = out_kind_r;
  assign out_status     = out_status_r;
  assign out_expired_id = out_id_r;
  assign out_last       = out_last_r;

endmodule

### rtl/core/sorted_timer_callout_queue.sv
// Sorted timer queue: a tick counter plus up to NUM_ENTRIES armed entries kept in
// ascending order of absolute expiry. An add request (tuser 1) arms an entry at
// uptime + delay and answers one status result; the queue position is found by a
// linear scan of the slot array, one slot per cycle, and a refused entry, which
// includes every add to a full queue, skips the scan.
// A tick request (tuser 0) bumps the counter and reports expired entries in queue
// order, last one flagged by tlast, popping the queue head one per cycle while the
// result side is not stalled; the status answer of an add also waits on a stalled result side.
// The result register lets one finished result wait while the next request is taken.
module sorted_timer_callout_queue import stq_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // entry_id [3:0], delay_ticks [35:4]
  input  logic                  in_tuser,   // command
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // status [0], expired_id [4:1]
  output logic                  out_tuser,  // kind
  output logic                  out_tlast
);

  stq_cmd_t        cmd;
  stq_stat_t       stat;
  logic            out_status;
  logic [ID_W-1:0] out_expired_id;

  stq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_is_add (in_tuser == CMD_ADD),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  stq_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .stat           (stat),
    .in_is_add      (in_tuser == CMD_ADD),
    .in_entry_id    (in_tdata[ID_W-1:0]),
    .in_delay_ticks (in_tdata[ID_W+DELAY_W-1:ID_W]),
    .out_valid      (out_tvalid),
    .out_ready      (out_tready),
    .out_kind       (out_tuser),
    .out_status     (out_status),
    .out_expired_id (out_expired_id),
    .out_last       (out_tlast)
  );

  assign out_tdata = {{(OUT_DATA_W - 1 - ID_W){1'b0}}, out_expired_id, out_status};

endmodule

### sim/tb.sv
// testbench for the sorted timer queue: random-paced stream driver, result monitor, predictor
module tb;
  import stq_pkg::*;

  localparam int IDLE_LIMIT = 4000;
  localparam int RAND_ITEMS = 184;

  typedef struct {
    logic               cmd;
    logic [ID_W-1:0]    id;
    logic [DELAY_W-1:0] delay;
  } timer_req_t;

  typedef struct {
    logic            kind;
    logic            status;
    logic [ID_W-1:0] id;
    logic            last;
  } timer_result_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  in_tuser = CMD_TICK;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;
  logic                  out_tlast;

  sorted_timer_callout_queue u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  // predicted timer state
  logic [TIME_W-1:0] uptime = '0;
  logic [TIME_W-1:0] expiry_at [NUM_ENTRIES];
  logic              armed [NUM_ENTRIES] = '{default: 1'b0};
  logic [ID_W-1:0]   order [NUM_ENTRIES];
  int                n_queued = 0;

  timer_req_t    requests_q [$];
  timer_result_t due_results [$];
  timer_req_t    cur;

  int errors = 0;
  int n_adds = 0, n_refused = 0, n_ticks = 0, n_expired = 0, max_burst = 0;
  int far_shots = 0;
  int idle_cycles = 0;
  int unsigned gap_left = 0, stall_left = 0, phase_left = 0;
  logic calm = 1'b0;
  logic req_taken = 1'b0;

  initial begin
    forever #1 clk = ~clk;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm || r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [ID_W-1:0] pick_id();
    logic [ID_W-1:0] c;
    int tries;
    c = ID_W'($urandom_range(0, NUM_ENTRIES - 1));
    if ($urandom_range(0, 99) < 12) return c;
    for (tries = 0; tries < 16; tries++) begin
      c = ID_W'($urandom_range(0, NUM_ENTRIES - 1));
      if (!armed[c]) return c;
    end
    return c;
  endfunction

  function automatic logic [DELAY_W-1:0] pick_delay();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) return $urandom_range(0, 1);
    if (r < 70) return $urandom_range(0, 8);
    if (r < 82) return $urandom_range(9, 40);
    // near the top of the range the expiry wraps to just behind uptime
    if (r < 94) return 32'hFFFF_FFFF - $urandom_range(0, 2);
    // a full-range delay almost never expires, so keep these few
    if (far_shots < 4) begin
      far_shots++;
      return $urandom;
    end
    return $urandom_range(0, 8);
  endfunction

  task automatic queue_add(input logic [ID_W-1:0] id, input logic [DELAY_W-1:0] delay);
    requests_q.push_back('{CMD_ADD, id, delay});
  endtask

  task automatic queue_tick();
    requests_q.push_back('{CMD_TICK, '0, '0});
  endtask

  task automatic report(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    errors++;
  endtask

  // update the timer state for one accepted request and queue what it must produce
  task automatic apply_request(input timer_req_t r);
    timer_result_t res;
    logic [TIME_W-1:0] when;
    logic [ID_W-1:0] slot_id;
    int pos, keep, fired;
    if (r.cmd == CMD_ADD) begin
      res = '{KIND_STATUS, STATUS_OK, '0, 1'b1};
      n_adds++;
      if (armed[r.id] || n_queued >= NUM_ENTRIES) begin
        res.status = STATUS_BUSY;
        n_refused++;
      end else begin
        when = uptime + r.delay;
        expiry_at[r.id] = when;
        armed[r.id] = 1'b1;
        // goes in front of the first entry due at or after it
        pos = n_queued;
        for (int k = 0; k < n_queued; k++) begin
          if (pos == n_queued && expiry_at[order[k]] >= when) pos = k;
        end
        for (int k = n_queued; k > pos; k--) order[k] = order[k-1];
        order[pos] = r.id;
        n_queued++;
      end
      due_results.push_back(res);
    end else begin
      n_ticks++;
      uptime = uptime + 1'b1;
      keep = 0;
      fired = 0;
      for (int k = 0; k < n_queued; k++) begin
        slot_id = order[k];
        if (expiry_at[slot_id] <= uptime) begin
          armed[slot_id] = 1'b0;
          due_results.push_back('{KIND_EXPIRED, STATUS_OK, slot_id, 1'b0});
          fired++;
        end else begin
          order[keep] = slot_id;
          keep++;
        end
      end
      n_queued = keep;
      if (fired > 0) begin
        res = due_results.pop_back();
        res.last = 1'b1;
        due_results.push_back(res);
      end
      n_expired += fired;
      if (fired > max_burst) max_burst = fired;
    end
  endtask

  task automatic check_result();
    timer_result_t want;
    if (due_results.size() == 0) begin
      report($sformatf("unexpected result kind %0d id %0d", out_tuser, out_tdata[4:1]));
      return;
    end
    want = due_results.pop_front();
    if (out_tuser !== want.kind)
      report($sformatf("kind expected %0d got %0d", want.kind, out_tuser));
    if (out_tdata[0] !== want.status)
      report($sformatf("status expected %0d got %0d", want.status, out_tdata[0]));
    if (out_tdata[4:1] !== want.id)
      report($sformatf("expired id expected %0d got %0d", want.id, out_tdata[4:1]));
    if (out_tlast !== want.last)
      report($sformatf("last flag expected %0d got %0d (id %0d)", want.last, out_tlast, want.id));
  endtask

  // monitor, predictor trigger and watchdog
  always @(posedge clk) begin
    if (!rst_n) begin
      req_taken = 1'b0;
    end else begin
      req_taken = in_tvalid && in_tready;
      if (out_tvalid && out_tready) check_result();
      if (req_taken) apply_request(cur);
      if (req_taken || (out_tvalid && out_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles == IDLE_LIMIT) begin
        $display("timeout: no handshake for %0d cycles, %0d results outstanding",
                 IDLE_LIMIT, due_results.size());
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

  // request driver
  always @(negedge clk) begin
    logic nxt_valid;
    nxt_valid = in_tvalid;
    if (rst_n) begin
      if (in_tvalid && req_taken) begin
        nxt_valid = 1'b0;
        gap_left = pick_gap();
      end
      if (!nxt_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (requests_q.size() > 0) begin
          cur = requests_q.pop_front();
          in_tdata <= {{(IN_DATA_W - ID_W - DELAY_W){1'b0}}, cur.delay, cur.id};
          in_tuser <= cur.cmd;
          nxt_valid = 1'b1;
        end
      end
    end
    in_tvalid <= nxt_valid;
  end

  // result side back-pressure, with calm stretches where neither side idles
  always @(negedge clk) begin
    if (phase_left == 0) begin
      calm = ($urandom_range(0, 3) == 0);
      phase_left = $urandom_range(20, 80);
    end else begin
      phase_left--;
    end
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
      if ($urandom_range(0, 3) == 0) stall_left = pick_gap();
    end
  end

  initial begin
    int add_bias;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: empty tick, delay extremes, duplicate add, wrapped expiry, ties
    queue_tick();
    queue_add(4'd0, 32'd0);
    queue_add(4'd0, 32'd5);
    queue_add(4'd15, 32'hFFFF_FFFF);
    queue_add(4'd5, 32'd2);
    queue_add(4'd9, 32'd2);
    queue_tick();
    queue_tick();
    // fill the whole queue so one tick empties it
    for (int k = 0; k < NUM_ENTRIES; k++) begin
      case (k % 3)
        0: begin
          queue_add(ID_W'(k), 32'd0);
        end
        1: begin
          queue_add(ID_W'(k), 32'd1);
        end
        default: begin
          queue_add(ID_W'(k), 32'hFFFF_FFFF);
        end
      endcase
    end
    queue_add(4'd7, 32'd3);
    queue_tick();

    add_bias = 50;
    for (int n = 0; n < RAND_ITEMS; n++) begin
      while (requests_q.size() >= 2) @(posedge clk);
      if (n % 20 == 0) add_bias = $urandom_range(30, 75);
      if ($urandom_range(0, 99) < add_bias) queue_add(pick_id(), pick_delay());
      else queue_tick();
    end

    while (requests_q.size() > 0 || in_tvalid || due_results.size() > 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("ran %0d adds (%0d refused) and %0d ticks; %0d expiries checked",
             n_adds, n_refused, n_ticks, n_expired);
    $display("largest burst on one tick: %0d entries, uptime ended at %0d", max_burst, uptime);
    if (errors == 0 && due_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
